// ===== rtl/plt_pkg.sv =====
// plt_pkg: shared constants, status codes and the command struct
// of the packet loss rate tracker; depends on nothing
`default_nettype none

package plt_pkg;

    localparam int COUNT_WIDTH = 48;
    localparam int QUEUE_DEPTH = 2;

    localparam int RATE_WIDTH = 32;
    localparam int SCALE_BITS = 17;

    // thousandths of a percent
    localparam logic [SCALE_BITS-1:0] RATE_SCALE = 17'd100000;
    localparam logic [RATE_WIDTH-1:0] RATE_SAT   = 32'hFFFF_FFFF;
    localparam logic [RATE_WIDTH-1:0] MIN_RESET  = 32'd2147483647;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RECV_HIGH = 2'd1;
    localparam logic [1:0] STATUS_SENT_BACK = 2'd2;

    // control part of one command from the front to the back
    typedef struct packed {
        logic [1:0] status;
        logic       calc;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/plt_front.sv =====
// plt_front: accepts reports, checks them on their own and against the last OK
// report, and issues commands with the loss and sent deltas; uses plt_pkg
`default_nettype none

module plt_front #(
    parameter int COUNT_WIDTH = plt_pkg::COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [COUNT_WIDTH-1:0] i_sent_count,
    input  wire logic [COUNT_WIDTH-1:0] i_received_count,
    input  wire logic                   i_full,
    output logic                        o_push,
    output plt_pkg::t_cmd               o_cmd,
    output logic [COUNT_WIDTH-1:0]      o_dl,
    output logic [COUNT_WIDTH-1:0]      o_ds
);

    logic                   r_have_prev;
    logic [COUNT_WIDTH-1:0] r_prev_sent;
    logic [COUNT_WIDTH-1:0] r_prev_lost;
    logic [COUNT_WIDTH-1:0] lost;
    logic [1:0]             status;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign lost       = i_sent_count - i_received_count;

    always_comb begin
        if (i_received_count > i_sent_count) begin
            status = plt_pkg::STATUS_RECV_HIGH;
        end else if (i_sent_count < r_prev_sent) begin
            status = plt_pkg::STATUS_SENT_BACK;
        end else begin
            status = plt_pkg::STATUS_OK;
        end
    end

    assign o_cmd.status = status;
    assign o_cmd.calc   = (status == plt_pkg::STATUS_OK) && r_have_prev && (lost > r_prev_lost);
    assign o_dl         = lost - r_prev_lost;
    assign o_ds         = i_sent_count - r_prev_sent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_sent <= '0;
            r_prev_lost <= '0;
        end else if (o_push && status == plt_pkg::STATUS_OK) begin
            r_have_prev <= 1'b1;
            r_prev_sent <= i_sent_count;
            r_prev_lost <= lost;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/plt_queue.sv =====
// plt_queue: short command queue between front and back
// uses plt_pkg for the command struct
`default_nettype none

module plt_queue #(
    parameter int COUNT_WIDTH = plt_pkg::COUNT_WIDTH,
    parameter int QUEUE_DEPTH = plt_pkg::QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire plt_pkg::t_cmd          i_cmd,
    input  wire logic [COUNT_WIDTH-1:0] i_dl,
    input  wire logic [COUNT_WIDTH-1:0] i_ds,
    output logic                        o_full,
    input  wire logic                   i_pop,
    output logic                        o_valid,
    output plt_pkg::t_cmd               o_cmd,
    output logic [COUNT_WIDTH-1:0]      o_dl,
    output logic [COUNT_WIDTH-1:0]      o_ds
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    plt_pkg::t_cmd          r_cmd_q [QUEUE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_dl_q  [QUEUE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_ds_q  [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_head;
    logic [PTR_W-1:0]       r_tail;
    logic [CNT_W-1:0]       r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_cmd_q[r_head];
    assign o_dl    = r_dl_q[r_head];
    assign o_ds    = r_ds_q[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd_q[r_tail] <= i_cmd;
            r_dl_q[r_tail]  <= i_dl;
            r_ds_q[r_tail]  <= i_ds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= next_ptr(r_tail);
            end
            if (i_pop) begin
                r_head <= next_ptr(r_head);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full command queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty command queue");

endmodule

`default_nettype wire

// ===== rtl/plt_back.sv =====
// plt_back: serial shift-add multiply by the rate scale, then a 32-step
// restoring divide, min/max tracking and the result register; uses plt_pkg
`default_nettype none

module plt_back #(
    parameter int COUNT_WIDTH = plt_pkg::COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_pop,
    input  wire plt_pkg::t_cmd          i_cmd,
    input  wire logic [COUNT_WIDTH-1:0] i_dl,
    input  wire logic [COUNT_WIDTH-1:0] i_ds,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [1:0]                  o_status,
    output logic [31:0]                 o_latest_rate,
    output logic [31:0]                 o_min_rate,
    output logic [31:0]                 o_max_rate
);

    localparam int RW    = plt_pkg::RATE_WIDTH;
    localparam int SB    = plt_pkg::SCALE_BITS;
    localparam int NW    = COUNT_WIDTH + SB;
    localparam int HI_W  = NW - RW;
    localparam int PAD_W = COUNT_WIDTH - HI_W;
    localparam int CNT_W = $clog2(RW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    plt_pkg::t_cmd          r_cmd, n_cmd;
    logic [COUNT_WIDTH-1:0] r_dl, n_dl;
    logic [COUNT_WIDTH-1:0] r_ds, n_ds;
    logic [NW-1:0]          r_acc, n_acc;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem;
    logic [RW-1:0]          r_q, n_q;
    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_status, n_status;
    logic [RW-1:0]          r_latest, n_latest;
    logic [RW-1:0]          r_min, n_min;
    logic [RW-1:0]          r_max, n_max;

    logic                   fin_fire;
    logic [COUNT_WIDTH-1:0] hi_ext;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH-1:0] diff;
    logic                   ge;

    assign o_pop         = (r_state == S_IDLE) && i_valid;
    assign fin_fire      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_latest_rate = r_latest;
    assign o_min_rate    = r_min;
    assign o_max_rate    = r_max;

    // product bits above the quotient width: quotient fits iff this is below ds
    assign hi_ext = {{PAD_W{1'b0}}, r_acc[NW-1:RW]};
    assign trial  = {r_rem, r_q[RW-1]};
    // remainder stays below ds, so the difference fits the count width
    assign diff   = trial[COUNT_WIDTH-1:0] - r_ds;
    assign ge     = (trial >= {1'b0, r_ds});

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_dl        = r_dl;
        n_ds        = r_ds;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_q         = r_q;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_latest    = r_latest;
        n_min       = r_min;
        n_max       = r_max;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_dl  = i_dl;
                    n_ds  = i_ds;
                    n_acc = '0;
                    n_cnt = CNT_W'(SB - 1);
                    n_state = i_cmd.calc ? S_MUL : S_FIN;
                end
            end
            S_MUL: begin
                n_acc = {r_acc[NW-2:0], 1'b0}
                      + (plt_pkg::RATE_SCALE[r_cnt] ? {{SB{1'b0}}, r_dl} : NW'(0));
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // also covers a zero sent delta
                if (hi_ext >= r_ds) begin
                    n_q     = plt_pkg::RATE_SAT;
                    n_state = S_FIN;
                end else begin
                    n_rem   = hi_ext;
                    n_q     = r_acc[RW-1:0];
                    n_cnt   = CNT_W'(RW - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = ge ? diff : trial[COUNT_WIDTH-1:0];
                n_q   = {r_q[RW-2:0], ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_fire) begin
                    n_out_valid = 1'b1;
                    n_status    = r_cmd.status;
                    if (r_cmd.status == plt_pkg::STATUS_OK) begin
                        if (r_cmd.calc) begin
                            n_latest = r_q;
                            if (r_q < r_min) begin
                                n_min = r_q;
                            end
                            if (r_q > r_max) begin
                                n_max = r_q;
                            end
                        end else begin
                            n_latest = '0;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_latest    <= '0;
            r_min       <= plt_pkg::MIN_RESET;
            r_max       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_latest    <= n_latest;
            r_min       <= n_min;
            r_max       <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_cmd    <= n_cmd;
        r_dl     <= n_dl;
        r_ds     <= n_ds;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_status <= n_status;
    end

    a_rem_below_ds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_ds))
        else $error("divider remainder not below divisor");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max != '0) |-> (r_min <= r_max))
        else $error("minimum rate above maximum rate");

    a_reject_keeps_latest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_fire && r_cmd.status != plt_pkg::STATUS_OK) |=> $stable(r_latest))
        else $error("rejected report changed the latest rate");

endmodule

`default_nettype wire

// ===== rtl/packet_loss_rate_tracker.sv =====
// packet_loss_rate_tracker: loss rate from cumulative sent/received reports
// a report that needs a rate passes a shift-add multiply, a range check and a
// serial divide before its result; other reports go straight to the result
// the back takes no new report before it has issued the result of the last one;
// a two-entry command queue lets the front keep accepting until the queue is full
// reset: synchronous, clears control state and rates; min rate returns to 2147483647
`default_nettype none

module packet_loss_rate_tracker #(
    parameter int COUNT_WIDTH = plt_pkg::COUNT_WIDTH,
    parameter int QUEUE_DEPTH = plt_pkg::QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [COUNT_WIDTH-1:0] i_sent_count,
    input  wire logic [COUNT_WIDTH-1:0] i_received_count,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [1:0]                  o_status,
    output logic [31:0]                 o_latest_rate,
    output logic [31:0]                 o_min_rate,
    output logic [31:0]                 o_max_rate
);

    logic                   push;
    logic                   full;
    plt_pkg::t_cmd          front_cmd;
    logic [COUNT_WIDTH-1:0] front_dl;
    logic [COUNT_WIDTH-1:0] front_ds;
    logic                   pop;
    logic                   q_valid;
    plt_pkg::t_cmd          q_cmd;
    logic [COUNT_WIDTH-1:0] q_dl;
    logic [COUNT_WIDTH-1:0] q_ds;

    plt_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sent_count     (i_sent_count),
        .i_received_count (i_received_count),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (front_cmd),
        .o_dl             (front_dl),
        .o_ds             (front_ds)
    );

    plt_queue #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_dl    (front_dl),
        .i_ds    (front_ds),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_dl    (q_dl),
        .o_ds    (q_ds)
    );

    plt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .o_pop         (pop),
        .i_cmd         (q_cmd),
        .i_dl          (q_dl),
        .i_ds          (q_ds),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_latest_rate (o_latest_rate),
        .o_min_rate    (o_min_rate),
        .o_max_rate    (o_max_rate)
    );

endmodule

`default_nettype wire
